[design/ufmc_pkg.sv]
package ufmc_pkg;

  // default grid bounds
  localparam int MAX_ROWS_DEF = 64;
  localparam int MAX_COLS_DEF = 64;

  // field widths
  localparam int DIM_W  = 7;
  localparam int SETS_W = 13;
  localparam int TOT_W  = 2 * DIM_W;

  // configuration port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  // input item
  typedef struct packed {
    logic [DIM_W-1:0] cell_row;
    logic [DIM_W-1:0] cell_col;
    logic             direction;
  } ufmc_in_t;

  // result item
  typedef struct packed {
    logic              carved;
    logic [SETS_W-1:0] sets_left;
    logic              done_res;
  } ufmc_out_t;

  // controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL,
    ST_READ_A,
    ST_FIND_A,
    ST_READ_B,
    ST_FIND_B,
    ST_RESULT
  } ufmc_state_e;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic load;
    logic eval;
    logic rd_cur;
    logic walk_a;
    logic walk_b;
  } ufmc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic go;
    logic at_root;
  } ufmc_stat_t;

endpackage

[design/union_find_maze_carver_unit.sv]
// an accepted item passes through EVAL and RESULT when the wall is not tried,
//   else through EVAL, READ_A, FIND_A, READ_B, FIND_B and RESULT, the FIND states
//   walking the parent chains of the two cells, one store read per chain step
// one item at a time: start is taken only in IDLE, while busy is low
// reset: a sweep over all MaxRows*MaxCols cells rewrites the parent store, busy high
// results appear for one cycle on result_strobe_o; the receiver cannot stall
module union_find_maze_carver_unit #(
  parameter int MaxRows = ufmc_pkg::MAX_ROWS_DEF,
  parameter int MaxCols = ufmc_pkg::MAX_COLS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  ufmc_pkg::ufmc_in_t            in_item_i,
  output logic                          result_strobe_o,
  output ufmc_pkg::ufmc_out_t           result_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ufmc_pkg::APB_AW-1:0]   paddr,
  input  logic [ufmc_pkg::APB_DW-1:0]   pwdata,
  output logic [ufmc_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);

  logic [ufmc_pkg::DIM_W-1:0] grid_rows_q, grid_cols_q;
  logic                       cfg_we;
  ufmc_pkg::ufmc_cmd_t        cmd;
  ufmc_pkg::ufmc_stat_t       stat;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_rows_q <= ufmc_pkg::DIM_W'(64);
      grid_cols_q <= ufmc_pkg::DIM_W'(64);
    end else if (cfg_we) begin
      if (paddr[2] == ufmc_pkg::REG_ROWS) begin
        grid_rows_q <= pwdata[ufmc_pkg::DIM_W-1:0];
      end else begin
        grid_cols_q <= pwdata[ufmc_pkg::DIM_W-1:0];
      end
    end
  end

  // register readback
  always_comb begin
    prdata = '0;
    if (paddr[2] == ufmc_pkg::REG_ROWS) begin
      prdata[ufmc_pkg::DIM_W-1:0] = grid_rows_q;
    end else begin
      prdata[ufmc_pkg::DIM_W-1:0] = grid_cols_q;
    end
  end

  ufmc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .stat_i   (stat),
    .cmd_o    (cmd),
    .busy     (busy),
    .strobe_o (result_strobe_o)
  );

  ufmc_dp #(
    .MaxRows (MaxRows),
    .MaxCols (MaxCols)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .grid_rows_i (grid_rows_q),
    .grid_cols_i (grid_cols_q),
    .item_i      (in_item_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .result_o    (result_o)
  );

endmodule

[design/ufmc_ctrl.sv]
module ufmc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  ufmc_pkg::ufmc_stat_t stat_i,
  output ufmc_pkg::ufmc_cmd_t  cmd_o,
  output logic                busy,
  output logic                strobe_o
);

  ufmc_pkg::ufmc_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ufmc_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d  = state_q;
    cmd_o    = '0;
    busy     = 1'b1;
    strobe_o = 1'b0;
    case (state_q)
      ufmc_pkg::ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (stat_i.clear_last) begin
          state_d = ufmc_pkg::ST_IDLE;
        end
      end
      ufmc_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = ufmc_pkg::ST_EVAL;
        end
      end
      ufmc_pkg::ST_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = stat_i.go ? ufmc_pkg::ST_READ_A : ufmc_pkg::ST_RESULT;
      end
      ufmc_pkg::ST_READ_A: begin
        cmd_o.rd_cur = 1'b1;
        state_d      = ufmc_pkg::ST_FIND_A;
      end
      ufmc_pkg::ST_FIND_A: begin
        cmd_o.walk_a = 1'b1;
        if (stat_i.at_root) begin
          state_d = ufmc_pkg::ST_READ_B;
        end
      end
      ufmc_pkg::ST_READ_B: begin
        cmd_o.rd_cur = 1'b1;
        state_d      = ufmc_pkg::ST_FIND_B;
      end
      ufmc_pkg::ST_FIND_B: begin
        cmd_o.walk_b = 1'b1;
        if (stat_i.at_root) begin
          state_d = ufmc_pkg::ST_RESULT;
        end
      end
      ufmc_pkg::ST_RESULT: begin
        strobe_o = 1'b1;
        state_d  = ufmc_pkg::ST_IDLE;
      end
      default: begin
        state_d = ufmc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[design/ufmc_dp.sv]
module ufmc_dp #(
  parameter int MaxRows = ufmc_pkg::MAX_ROWS_DEF,
  parameter int MaxCols = ufmc_pkg::MAX_COLS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [ufmc_pkg::DIM_W-1:0]    grid_rows_i,
  input  logic [ufmc_pkg::DIM_W-1:0]    grid_cols_i,
  input  ufmc_pkg::ufmc_in_t            item_i,
  input  ufmc_pkg::ufmc_cmd_t           cmd_i,
  output ufmc_pkg::ufmc_stat_t          stat_o,
  output ufmc_pkg::ufmc_out_t           result_o
);

  localparam int CellCount = MaxRows * MaxCols;
  localparam int IdxW      = $clog2(CellCount);
  localparam int DimW      = ufmc_pkg::DIM_W;
  localparam int TotW      = ufmc_pkg::TOT_W;
  localparam int SetsW     = ufmc_pkg::SETS_W;

  // parent store, no reset: cleared by a sweep
  logic [IdxW-1:0] parent_mem_q [CellCount];
  logic [IdxW-1:0] rdata_q;
  logic [IdxW-1:0] raddr, waddr, wdata;
  logic            we;

  logic [IdxW-1:0] clr_q;
  logic [IdxW-1:0] join_q;
  logic [IdxW-1:0] cur_q, there_q, ra_q;
  logic [DimW-1:0] row_q, col_q, rows_q, cols_q;
  logic            dir_q;
  logic [TotW-1:0] total_q;
  logic            carved_q;

  logic [DimW-1:0] rows_c, cols_c;
  logic [TotW-1:0] total_d;
  logic [IdxW-1:0] here, there;
  logic            in_grid, has_next, more_sets, at_root;
  logic [31:0]     left32;

  // clamp grid size registers
  always_comb begin
    rows_c = grid_rows_i;
    if (grid_rows_i == '0) begin
      rows_c = DimW'(1);
    end else if (int'(grid_rows_i) > MaxRows) begin
      rows_c = DimW'(MaxRows);
    end
    cols_c = grid_cols_i;
    if (grid_cols_i == '0) begin
      cols_c = DimW'(1);
    end else if (int'(grid_cols_i) > MaxCols) begin
      cols_c = DimW'(MaxCols);
    end
  end

  // cell decode and carve decision
  always_comb begin
    total_d   = TotW'(rows_q) * TotW'(cols_q);
    in_grid   = (row_q != '0) && (row_q <= rows_q) && (col_q != '0) && (col_q <= cols_q);
    has_next  = dir_q ? (row_q < rows_q) : (col_q < cols_q);
    more_sets = (32'(join_q) + 32'd1) < 32'(total_d);
    here      = IdxW'(32'(row_q - DimW'(1)) * 32'(MaxCols) + 32'(col_q - DimW'(1)));
    there     = dir_q ? (here + IdxW'(MaxCols)) : (here + IdxW'(1));
  end

  assign at_root = (rdata_q == cur_q);

  assign stat_o.clear_last = (clr_q == IdxW'(CellCount - 1));
  assign stat_o.go         = in_grid && has_next && more_sets;
  assign stat_o.at_root    = at_root;

  // memory port selection
  always_comb begin
    raddr = cmd_i.rd_cur ? cur_q : rdata_q;
    we    = cmd_i.clear || (cmd_i.walk_b && at_root && (ra_q != cur_q));
    waddr = cmd_i.clear ? clr_q : ra_q;
    wdata = cmd_i.clear ? clr_q : cur_q;
  end

  // parent store
  always_ff @(posedge clk_i) begin
    if (we) begin
      parent_mem_q[waddr] <= wdata;
    end
    rdata_q <= parent_mem_q[raddr];
  end

  // clear sweep counter and join count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      join_q <= '0;
    end else begin
      if (cmd_i.clear) begin
        clr_q <= clr_q + IdxW'(1);
      end
      if (cmd_i.walk_b && at_root && (ra_q != cur_q)) begin
        join_q <= join_q + IdxW'(1);
      end
    end
  end

  // item registers and root walks
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      row_q  <= item_i.cell_row;
      col_q  <= item_i.cell_col;
      dir_q  <= item_i.direction;
      rows_q <= rows_c;
      cols_q <= cols_c;
    end
    if (cmd_i.eval) begin
      total_q  <= total_d;
      cur_q    <= here;
      there_q  <= there;
      carved_q <= 1'b0;
    end
    if (cmd_i.walk_a) begin
      if (at_root) begin
        ra_q  <= cur_q;
        cur_q <= there_q;
      end else begin
        cur_q <= rdata_q;
      end
    end
    if (cmd_i.walk_b) begin
      if (at_root) begin
        carved_q <= (ra_q != cur_q);
      end else begin
        cur_q <= rdata_q;
      end
    end
  end

  // result fields
  always_comb begin
    left32 = 32'(total_q) - 32'(join_q);
    result_o.carved    = carved_q;
    result_o.done_res  = (32'(join_q) + 32'd1) >= 32'(total_q);
    result_o.sets_left = (32'(join_q) >= 32'(total_q)) ? SetsW'(1) : SetsW'(left32);
  end

endmodule
